// ===== rtl/fpalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared types, codes and helpers for the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpalu_pkg;

    // Number of fraction bits in the raw fixed-point format
    localparam int FRACTIONAL_BITS = 8;

    // Number of divider quotient steps (one per stage)
    localparam int DIV_STEPS = 32;

    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_INC  = 4'd4,
        CMD_DEC  = 4'd5,
        CMD_MIN  = 4'd6,
        CMD_MAX  = 4'd7,
        CMD_ITOF = 4'd8,
        CMD_FTOI = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // Value with its status
    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } res_t;

    // Payload carried down the pipeline
    typedef struct packed {
        logic [3:0]  cmd;
        logic        lt;
        logic        eq;
        logic [31:0] value;
        status_t     status;
        logic        neg;
        logic        divzero;
        logic        ovf;
        logic [63:0] prod;
        logic [63:0] rem;
        logic [32:0] dvs;
        logic [31:0] quo;
    } stage_t;

    // Saturate sign and magnitude to 32 bits
    function automatic res_t sat_mag(input logic neg, input logic [63:0] m);
        res_t r;
        r.status = ST_OK;
        if (neg) begin
            if (m > 64'h0000_0000_8000_0000) begin
                r.value  = MIN32;
                r.status = ST_OVF;
            end
            else begin
                r.value = 32'(~m[31:0]) + 32'd1;
            end
        end
        else begin
            if (m > 64'h0000_0000_7FFF_FFFF) begin
                r.value  = MAX32;
                r.status = ST_OVF;
            end
            else begin
                r.value = m[31:0];
            end
        end
        return r;
    endfunction

    // Saturate a 33-bit signed sum to 32 bits
    function automatic res_t sat33(input logic [32:0] s);
        res_t r;
        r.status = ST_OK;
        r.value  = s[31:0];
        if (s[32] != s[31]) begin
            r.status = ST_OVF;
            r.value  = s[32] ? MIN32 : MAX32;
        end
        return r;
    endfunction

endpackage

// ===== rtl/fpalu_div.sv =====
// ----------------------------------------------------------------------------
// fpalu_div
// Pipelined restoring divider: one quotient bit per stage, side data rides
// along with each stage.
// ----------------------------------------------------------------------------
module fpalu_div
    import fpalu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_vld,
    input  stage_t in_st,
    output logic   out_vld,
    output stage_t out_st
);

    // One restoring step for quotient bit j
    function automatic stage_t div_step(input stage_t s, input logic [4:0] j);
        stage_t      r;
        logic [64:0] dsh;
        r   = s;
        dsh = 65'(s.dvs) << j;
        if ({1'b0, s.rem} >= dsh) begin
            r.rem    = s.rem - dsh[63:0];
            r.quo[j] = 1'b1;
        end
        return r;
    endfunction

    stage_t               st_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++) begin : g_step
            // Valid bit for this stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= (i == 0) ? in_vld : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end

            // Payload for this stage
            if (i == 0) begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        st_reg[i] <= div_step(in_st, 5'(DIV_STEPS - 1 - i));
                    end
                end
            end
            else begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        st_reg[i] <= div_step(st_reg[i-1], 5'(DIV_STEPS - 1 - i));
                    end
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[DIV_STEPS-1];
    assign out_st  = st_reg[DIV_STEPS-1];

endmodule

// ===== rtl/fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed 32-bit fixed-point ALU, fully pipelined, one operation per cycle unless res stalls.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// op       | op_valid / op_ready  | cmd, operand_a, operand_b
// res      | res_valid / res_ready| result_value, a_less_than_b, a_equals_b,
//          |                      | status
//
// 36 register stages for every command: input register, decode/multiply,
// rounding and divide range check, 32 divider stages (one quotient bit each),
// output register.
// One transfer per cycle is accepted while res is not stalled.
// Reset clears only the valid bits. A stall on res holds the whole pipeline.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit
    import fpalu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] result_value,
    output logic               a_less_than_b,
    output logic               a_equals_b,
    output logic [1:0]         status
);

    localparam logic [63:0] HALF = (64'd1 << FRACTIONAL_BITS) >> 1;

    logic adv;

    logic               a_vld_reg;
    logic [3:0]         a_cmd_reg;
    logic signed [31:0] a_opa_reg;
    logic signed [31:0] a_opb_reg;

    logic   b_vld_reg;
    stage_t b_reg;
    stage_t b_next;
    logic   c_vld_reg;
    stage_t c_reg;
    stage_t c_next;

    logic   d_vld;
    stage_t d_st;

    logic        out_vld_reg;
    res_t        out_res_reg;
    res_t        out_res_next;
    logic        out_lt_reg;
    logic        out_eq_reg;

    // Whole pipeline moves unless the output is held
    assign adv      = !out_vld_reg || res_ready;
    assign op_ready = adv;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= op_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            out_vld_reg <= d_vld;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmd_reg   <= cmd;
            a_opa_reg   <= operand_a;
            a_opb_reg   <= operand_b;
            b_reg       <= b_next;
            c_reg       <= c_next;
            out_res_reg <= out_res_next;
            out_lt_reg  <= d_st.lt;
            out_eq_reg  <= d_st.eq;
        end
    end

    // Decode, simple ops, multiply, divider setup
    always_comb
    begin
        logic [31:0] ma;
        logic [31:0] mb;
        res_t        r;
        ma = a_opa_reg[31] ? 32'(~a_opa_reg) + 32'd1 : 32'(a_opa_reg);
        mb = a_opb_reg[31] ? 32'(~a_opb_reg) + 32'd1 : 32'(a_opb_reg);
        r.value  = '0;
        r.status = ST_OK;
        case (a_cmd_reg)
            CMD_ADD: r = sat33({a_opa_reg[31], a_opa_reg} + {a_opb_reg[31], a_opb_reg});
            CMD_SUB: r = sat33({a_opa_reg[31], a_opa_reg} - {a_opb_reg[31], a_opb_reg});
            CMD_INC: r = sat33({a_opa_reg[31], a_opa_reg} + 33'd1);
            CMD_DEC: r = sat33({a_opa_reg[31], a_opa_reg} - 33'd1);
            CMD_MIN: r.value = (a_opa_reg <= a_opb_reg) ? a_opa_reg : a_opb_reg;
            CMD_MAX: r.value = (a_opa_reg >= a_opb_reg) ? a_opa_reg : a_opb_reg;
            CMD_ITOF: r = sat_mag(a_opa_reg[31], {32'd0, ma} << FRACTIONAL_BITS);
            CMD_FTOI: r.value = 32'(a_opa_reg >>> FRACTIONAL_BITS);
            CMD_DIV:
            begin
                // divide by zero result; overwritten later for a nonzero divisor
                r.status = ST_DIVZ;
                if (a_opa_reg[31])
                    r.value = MIN32;
                else if (a_opa_reg != 32'sd0)
                    r.value = MAX32;
                else
                    r.value = '0;
            end
            default: r.value = '0;
        endcase
        b_next.cmd     = a_cmd_reg;
        b_next.lt      = a_opa_reg < a_opb_reg;
        b_next.eq      = a_opa_reg == a_opb_reg;
        b_next.value   = r.value;
        b_next.status  = r.status;
        b_next.neg     = a_opa_reg[31] ^ a_opb_reg[31];
        b_next.divzero = (mb == 32'd0);
        b_next.ovf     = 1'b0;
        b_next.prod    = 64'(ma) * 64'(mb);
        // rounded quotient = (2n + d) / (2d)
        b_next.rem     = ((({32'd0, ma} << FRACTIONAL_BITS)) << 1) + {32'd0, mb};
        b_next.dvs     = {mb, 1'b0};
        b_next.quo     = '0;
    end

    // Multiply rounding and divide range check
    always_comb
    begin
        logic [63:0] rnd;
        res_t        r;
        c_next = b_reg;
        rnd    = (b_reg.prod + HALF) >> FRACTIONAL_BITS;
        r      = sat_mag(b_reg.neg, rnd);
        if (b_reg.cmd == CMD_MUL)
        begin
            c_next.value  = r.value;
            c_next.status = r.status;
        end
        c_next.ovf = {1'b0, b_reg.rem} >= {b_reg.dvs, 32'd0};
    end

    fpalu_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (c_vld_reg),
        .in_st   (c_reg),
        .out_vld (d_vld),
        .out_st  (d_st)
    );

    // Final divide result selection
    always_comb
    begin
        out_res_next.value  = d_st.value;
        out_res_next.status = d_st.status;
        if (d_st.cmd == CMD_DIV && !d_st.divzero)
        begin
            if (d_st.ovf)
            begin
                out_res_next.value  = d_st.neg ? MIN32 : MAX32;
                out_res_next.status = ST_OVF;
            end
            else
            begin
                out_res_next = sat_mag(d_st.neg, {32'd0, d_st.quo});
            end
        end
    end

    assign res_valid     = out_vld_reg;
    assign result_value  = out_res_reg.value;
    assign status        = out_res_reg.status;
    assign a_less_than_b = out_lt_reg;
    assign a_equals_b    = out_eq_reg;

endmodule

// ===== tb/fixed_point_alu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_alu_checker
// Watches the op and res channels, computes the expected ALU result for each
// op transfer and compares every res transfer against the oldest one.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker
    import fpalu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  logic               op_ready,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic signed [31:0] result_value,
    input  logic               a_less_than_b,
    input  logic               a_equals_b,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct {
        logic signed [31:0] value;
        logic               lt;
        logic               eq;
        logic [1:0]         st;
    } alu_out_t;

    alu_out_t expected_results[$];

    // Clamp a sign and magnitude to the signed 32-bit range
    function automatic logic signed [31:0] clamp_mag(input logic neg,
                                                     input logic [63:0] m,
                                                     inout logic [1:0] st);
        if (neg) begin
            if (m > 64'h8000_0000) begin
                st = ST_OVF;
                return 32'sh8000_0000;
            end
            return 32'(-$signed({1'b0, m}));
        end
        if (m > 64'h7FFF_FFFF) begin
            st = ST_OVF;
            return 32'sh7FFF_FFFF;
        end
        return m[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_wide(input longint v,
                                                      inout logic [1:0] st);
        if (v > 64'sd2147483647) begin
            st = ST_OVF;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            st = ST_OVF;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic alu_out_t compute_alu(input logic [3:0] c,
                                             input logic signed [31:0] ra,
                                             input logic signed [31:0] rb);
        alu_out_t   o;
        longint     a;
        longint     b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] p;
        logic [1:0]  st;
        a  = ra;
        b  = rb;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        st = ST_OK;
        o.value = '0;
        case (c)
            CMD_ADD: o.value = clamp_wide(a + b, st);
            CMD_SUB: o.value = clamp_wide(a - b, st);
            CMD_MUL:
            begin
                p = ma * mb;
                if (FRACTIONAL_BITS > 0)
                    p = (p + (64'd1 << (FRACTIONAL_BITS - 1))) >> FRACTIONAL_BITS;
                o.value = clamp_mag((a < 0) != (b < 0), p, st);
            end
            CMD_DIV:
            begin
                if (b == 0) begin
                    st = ST_DIVZ;
                    o.value = (a > 0) ? 32'sh7FFF_FFFF : (a < 0 ? 32'sh8000_0000 : 0);
                end
                else begin
                    p = ((2 * (ma << FRACTIONAL_BITS)) + mb) / (2 * mb);
                    o.value = clamp_mag((a < 0) != (b < 0), p, st);
                end
            end
            CMD_INC:  o.value = clamp_wide(a + 1, st);
            CMD_DEC:  o.value = clamp_wide(a - 1, st);
            CMD_MIN:  o.value = (a <= b) ? ra : rb;
            CMD_MAX:  o.value = (a >= b) ? ra : rb;
            CMD_ITOF: o.value = clamp_mag(a < 0, ma << FRACTIONAL_BITS, st);
            CMD_FTOI: o.value = ra >>> FRACTIONAL_BITS;
            default:  o.value = '0;
        endcase
        o.lt = (a < b);
        o.eq = (a == b);
        o.st = st;
        return o;
    endfunction

    assign pending_count = expected_results.size();

    // Predict on op transfers, compare on res transfers
    always @(posedge clk) begin
        alu_out_t e;
        int       errs;
        errs = 0;
        if (rst_n && op_valid && op_ready)
            expected_results.push_back(compute_alu(cmd, operand_a, operand_b));
        if (rst_n && res_valid && res_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer, value %0d", result_value);
                errs++;
            end
            else begin
                e = expected_results.pop_front();
                if (result_value !== e.value) begin
                    $error("result_value expected %0d actual %0d", e.value, result_value);
                    errs++;
                end
                if (a_less_than_b !== e.lt) begin
                    $error("a_less_than_b expected %0b actual %0b", e.lt, a_less_than_b);
                    errs++;
                end
                if (a_equals_b !== e.eq) begin
                    $error("a_equals_b expected %0b actual %0b", e.eq, a_equals_b);
                    errs++;
                end
                if (status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errs++;
                end
            end
        end
        if (errs != 0)
            fail_count <= fail_count + errs;
    end

    initial fail_count = 0;

endmodule

// ===== tb/tb_fixed_point_alu_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_unit
// Drives directed corner operations and random traffic with random idling on
// both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_unit;
    import fpalu_pkg::*;

    localparam int RANDOM_OPS = 500;
    localparam int LATENCY    = 36;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               op_valid = 1'b0;
    logic               op_ready;
    logic [3:0]         cmd = '0;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic signed [31:0] result_value;
    logic               a_less_than_b;
    logic               a_equals_b;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending_count;
    logic               no_idle = 1'b0;

    always #5 clk = ~clk;

    fixed_point_alu_unit DUT (.*);

    fixed_point_alu_checker checker_i (.*);

    // Sink stalls at random except during the quiet stretch
    always @(posedge clk)
        res_ready <= no_idle || ($urandom_range(99) >= 37);

    // Pick an operand: corners often, otherwise random
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(2047)) - 1024);
            4: return 32'($signed($urandom_range(65535)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    // Valid drops only while idling, so back-to-back transfers keep it high
    task automatic send_op(input logic [3:0] c, input logic [31:0] a,
                           input logic [31:0] b);
        while (!no_idle && $urandom_range(99) < 37)
        begin
            op_valid <= 1'b0;
            @(posedge clk);
        end
        op_valid  <= 1'b1;
        cmd       <= c;
        operand_a <= a;
        operand_b <= b;
        do @(posedge clk); while (!op_ready);
    endtask

    initial begin
        logic [3:0] c;
        logic [31:0] a;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: saturation, rounding halves, divide by zero, ties, unknown
        send_op(CMD_ADD, 32'h7FFF_FFFF, 32'h1);
        send_op(CMD_SUB, 32'h8000_0000, 32'h1);
        send_op(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(CMD_MUL, 32'h8000_0000, 32'h100);
        send_op(CMD_MUL, 32'h1, 32'h80);
        send_op(CMD_MUL, 32'hFFFF_FFFF, 32'h80);
        send_op(CMD_DIV, 32'h5, 32'h0);
        send_op(CMD_DIV, 32'hFFFF_FFFB, 32'h0);
        send_op(CMD_DIV, 32'h0, 32'h0);
        send_op(CMD_DIV, 32'h1, 32'h200);
        send_op(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000);
        send_op(CMD_INC, 32'h7FFF_FFFF, 32'h0);
        send_op(CMD_DEC, 32'h8000_0000, 32'h0);
        send_op(CMD_MIN, 32'h1234, 32'h1234);
        send_op(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(CMD_ITOF, 32'h0080_0000, 32'h0);
        send_op(CMD_ITOF, 32'hFF80_0000, 32'h0);
        send_op(CMD_ITOF, 32'hFF7F_FFFF, 32'h0);
        send_op(CMD_FTOI, 32'hFFFF_FF01, 32'h0);
        send_op(CMD_FTOI, 32'h7FFF_FFFF, 32'h0);
        send_op(4'd10, 32'h1, 32'h2);
        send_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random traffic, with a quiet stretch in the middle
        for (int i = 0; i < RANDOM_OPS; i++) begin
            no_idle <= (i >= 200 && i < 280);
            c = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                          : 4'($urandom_range(9));
            a = pick_operand();
            send_op(c, a, ($urandom_range(7) == 0) ? a : pick_operand());
        end
        op_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
